[hdl/fefe_pkg.sv]
`default_nettype none
package fefe_pkg;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_FRAME = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] CFG_COLOR_COUNT = 2'd0;
  localparam logic [1:0] CFG_SPAWN_THR   = 2'd1;
  localparam logic [1:0] CFG_FLARE_ROWS  = 2'd2;
  localparam logic [1:0] CFG_COLOR_BASE  = 2'd3;

  localparam logic [8:0] DECAY_NUM  = 9'd14;
  localparam logic [8:0] DECAY_DEN  = 9'd10;
  localparam logic [8:0] ROUND_ADD  = 9'd5;
  localparam logic [7:0] HEAT_SUB   = 8'd6;
  localparam logic [2:0] JITTER_MAX = 3'd4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [47:0] jitter_pack;
    logic [6:0]  spawn_roll;
    logic [3:0]  spawn_col;
    logic [3:0]  spawn_row;
    logic [3:0]  read_row;
    logic [3:0]  read_col;
  } in_item_t;

  typedef struct packed {
    logic [7:0] intensity;
    logic [7:0] color_index;
    logic [3:0] flare_count;
  } out_item_t;

endpackage
`default_nettype wire

[hdl/fefe_ram.sv]
`default_nettype none
module fefe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hdl/fire_effect_frame_engine_core.sv]
// Operations: read, init and frame step; a frame step passes over every pixel, then over
// each flare's clipped area, and moves entries in the flare list.
// One item at a time; busy is high from the accepting edge until the result strobe.
// Work is paced by the pixel memory, which has one read port and one write port.
// Reset sets control and config registers to defaults and runs a clearing pass over
// the pixel memory with busy high. The receiver cannot stall: out_valid lasts one cycle.
`default_nettype none
module fire_effect_frame_engine_core
  import fefe_pkg::*;
#(
  parameter int PANEL_WIDTH  = 16,
  parameter int PANEL_HEIGHT = 16,
  parameter int MAX_FLARES   = 10
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  output out_item_t      out_item,
  input  wire logic      cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  localparam int CW = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
  localparam int RW = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
  localparam int AW = CW + RW;
  localparam int FW = (MAX_FLARES > 1) ? $clog2(MAX_FLARES) : 1;
  localparam logic [CW-1:0] CMAX = CW'(PANEL_WIDTH - 1);
  localparam logic [RW-1:0] RMAX = RW'(PANEL_HEIGHT - 1);
  localparam logic [3:0] NFL = 4'(MAX_FLARES);

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_INIT = 4'd2,
    S_SHR = 4'd3, S_SHW = 4'd4, S_FLD = 4'd5, S_FLW = 4'd6, S_FSETUP = 4'd7,
    S_PR = 4'd8, S_PW = 4'd9, S_FNEXT = 4'd10, S_MOVR = 4'd11, S_MOVW = 4'd12,
    S_READ = 4'd13, S_READ2 = 4'd14, S_DONE = 4'd15;

  logic [3:0] st_r, st_nxt;
  logic [7:0] cc_r, base_r;
  logic [6:0] thr_r;
  logic [4:0] frows_r;
  logic [3:0] live_r, live_nxt;
  in_item_t   it_r, it_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [3:0] k_r, k_nxt, m_r, m_nxt;
  logic spawn_r, spawn_nxt;
  logic [CW-1:0] fx_r, fx_nxt;
  logic [RW-1:0] fy_r, fy_nxt;
  logic [7:0] fz_r, fz_nxt;
  logic [RW-1:0] r0_r, r0_nxt, r1_r, r1_nxt;
  logic [CW-1:0] c0_r, c0_nxt, c1_r, c1_nxt;
  logic [8:0] sq_r, sq_nxt;
  logic [7:0] rint_r, rint_nxt;
  logic out_v_nxt;

  logic pwe; logic [AW-1:0] pwa, pra; logic [7:0] pwd, prd;
  logic fwe; logic [FW-1:0] fwa, fra; logic [15:0] fwd, frd;

  fefe_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_pix (
    .clk, .we(pwe), .waddr(pwa), .wdata(pwd), .raddr(pra), .rdata(prd));
  fefe_ram #(.WIDTH(16), .DEPTH(1 << FW)) u_flr (
    .clk, .we(fwe), .waddr(fwa), .wdata(fwd), .raddr(fra), .rdata(frd));

  function automatic logic [4:0] isqrt9(input logic [8:0] n);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 1; i < 23; i++)
      if (10'(i * i) <= {1'b0, n}) r = 5'(i);
    return r;
  endfunction

  logic [21:0] reach_p;
  logic [8:0] reach;
  logic [4:0] fx5, fy5;
  logic signed [10:0] lo_c, hi_c, lo_r, hi_r;
  logic signed [9:0] dxs, dys;
  logic [4:0] sr;
  logic [8:0] dnum;
  logic [16:0] dprod;
  logic [8:0] dround;
  logic [7:0] flv;
  logic [2:0] jit;
  logic [7:0] below_dec;
  logic [CW-1:0] sx; logic [RW-1:0] sy; logic [4:0] lim;

  always_comb begin
    // z*10/14 as z*11705 >> 14
    reach_p = 22'(fz_r) * 22'd11705;
    reach = 9'(reach_p >> 14) + 9'd1;
    fx5 = 5'(fx_r); fy5 = 5'(fy_r);
    lo_c = $signed(11'(fx5)) - $signed(11'(reach));
    hi_c = $signed(11'(fx5)) + $signed(11'(reach)) - 11'sd1;
    lo_r = $signed(11'(fy5)) - $signed(11'(reach));
    hi_r = $signed(11'(fy5)) + $signed(11'(reach)) - 11'sd1;
    dxs = $signed(10'(fx_r)) - $signed(10'(col_r));
    dys = $signed(10'(fy_r)) - $signed(10'(row_r));
    sr = isqrt9(sq_r);
    // divide by 10 as x*205 >> 11
    dnum = DECAY_NUM * 9'(sr) + ROUND_ADD;
    dprod = 17'(dnum) * 17'd205;
    dround = 9'(dprod >> 11);
    flv = (9'(fz_r) > dround) ? 8'(9'(fz_r) - dround) : 8'd0;
    jit = it_r.jitter_pack[3*col_r +: 3];
    if (jit > JITTER_MAX) jit = JITTER_MAX;
    below_dec = (prd != 8'd0) ? prd - 8'd1 : 8'd0;
    lim = (frows_r == 5'd0) ? 5'd0 : frows_r - 5'd1;
    sx = (5'(it_r.spawn_col) > 5'(CMAX)) ? CMAX : CW'(it_r.spawn_col);
    sy = (5'(it_r.spawn_row) > lim) ? RW'(lim) : RW'(it_r.spawn_row);
    if (5'(sy) > 5'(RMAX)) sy = RMAX;
  end

  always_comb begin
    st_nxt = st_r; live_nxt = live_r; it_nxt = it_r;
    row_nxt = row_r; col_nxt = col_r; k_nxt = k_r; m_nxt = m_r;
    spawn_nxt = spawn_r; fx_nxt = fx_r; fy_nxt = fy_r; fz_nxt = fz_r;
    r0_nxt = r0_r; r1_nxt = r1_r; c0_nxt = c0_r; c1_nxt = c1_r;
    sq_nxt = sq_r; rint_nxt = rint_r; out_v_nxt = 1'b0;
    pwe = 1'b0; pwa = {row_r, col_r}; pwd = 8'd0; pra = {row_r, col_r};
    fwe = 1'b0; fwa = FW'(k_r); fwd = 16'd0; fra = FW'(k_r);
    case (st_r)
      S_CLEAR: begin
        pwe = 1'b1;
        col_nxt = col_r + 1'b1;
        if (col_r == CMAX) begin
          col_nxt = '0; row_nxt = row_r + 1'b1;
          if (row_r == RMAX) begin row_nxt = '0; st_nxt = S_IDLE; end
        end
      end
      S_IDLE: begin
        if (start) begin
          it_nxt = in_item; row_nxt = '0; col_nxt = '0; k_nxt = '0; spawn_nxt = 1'b0;
          case (in_item.operation)
            OP_INIT:  st_nxt = S_INIT;
            OP_FRAME: begin row_nxt = RMAX; st_nxt = S_SHR; end
            OP_READ:  st_nxt = S_READ;
            default:  st_nxt = S_DONE;
          endcase
        end
      end
      S_INIT: begin
        pwe = 1'b1; pwd = (row_r == '0) ? cc_r - 8'd1 : 8'd0;
        col_nxt = col_r + 1'b1;
        if (col_r == CMAX) begin
          col_nxt = '0; row_nxt = row_r + 1'b1;
          if (row_r == RMAX) st_nxt = S_DONE;
        end
      end
      S_SHR: begin
        pra = (row_r == '0) ? {row_r, col_r} : {row_r - 1'b1, col_r};
        st_nxt = S_SHW;
      end
      S_SHW: begin
        pwa = {row_r, col_r};
        if (row_r != '0) begin
          pwe = 1'b1; pwd = below_dec;
        end else if (prd != 8'd0) begin
          pwe = 1'b1; pwd = 8'(jit) + cc_r - HEAT_SUB;
        end
        st_nxt = S_SHR; col_nxt = col_r + 1'b1;
        if (col_r == CMAX) begin
          col_nxt = '0; row_nxt = row_r - 1'b1;
          if (row_r == '0) begin row_nxt = '0; st_nxt = S_FLD; end
        end
      end
      S_FLD: begin
        fra = FW'(k_r);
        if (k_r < live_r && k_r < NFL) st_nxt = S_FLW;
        else if (live_r < NFL && it_r.spawn_roll <= thr_r) begin
          spawn_nxt = 1'b1; fx_nxt = sx; fy_nxt = sy; fz_nxt = cc_r - 8'd1;
          fwe = 1'b1; fwa = FW'(live_r); fwd = {cc_r - 8'd1, 4'(sy), 4'(sx)};
          live_nxt = live_r + 4'd1; st_nxt = S_FSETUP;
        end else st_nxt = S_DONE;
      end
      S_FLW: begin
        fx_nxt = CW'(frd[3:0]); fy_nxt = RW'(frd[7:4]); fz_nxt = frd[15:8];
        st_nxt = S_FSETUP;
      end
      S_FSETUP: begin
        c0_nxt = (lo_c < 0) ? '0 : CW'(lo_c);
        r0_nxt = (lo_r < 0) ? '0 : RW'(lo_r);
        c1_nxt = (hi_c > $signed(11'(CMAX))) ? CMAX : CW'(hi_c);
        r1_nxt = (hi_r > $signed(11'(RMAX))) ? RMAX : RW'(hi_r);
        row_nxt = (lo_r < 0) ? '0 : RW'(lo_r);
        col_nxt = (lo_c < 0) ? '0 : CW'(lo_c);
        st_nxt = S_PR;
      end
      S_PR: begin
        sq_nxt = 9'(dxs * dxs) + 9'(dys * dys);
        st_nxt = S_PW;
      end
      S_PW: begin
        if (flv > prd) begin
          pwe = 1'b1; pwd = flv;
        end
        st_nxt = S_PR; col_nxt = col_r + 1'b1;
        if (col_r == c1_r) begin
          col_nxt = c0_r; row_nxt = row_r + 1'b1;
          if (row_r == r1_r) st_nxt = S_FNEXT;
        end
      end
      S_FNEXT: begin
        if (spawn_r) st_nxt = S_DONE;
        else if (fz_r > 8'd1) begin
          fwe = 1'b1; fwa = FW'(k_r); fwd = {fz_r - 8'd1, 4'(fy_r), 4'(fx_r)};
          k_nxt = k_r + 4'd1; st_nxt = S_FLD;
        end else begin
          m_nxt = k_r + 4'd1; st_nxt = S_MOVR;
        end
      end
      S_MOVR: begin
        fra = FW'(m_r);
        if (m_r < live_r && m_r < NFL) st_nxt = S_MOVW;
        else begin live_nxt = live_r - 4'd1; st_nxt = S_FLD; end
      end
      S_MOVW: begin
        fwe = 1'b1; fwa = FW'(m_r - 4'd1); fwd = frd;
        m_nxt = m_r + 4'd1; st_nxt = S_MOVR;
      end
      S_READ: begin
        pra = {RW'(it_r.read_row), CW'(it_r.read_col)};
        st_nxt = S_READ2;
      end
      S_READ2: begin
        rint_nxt = (32'(it_r.read_row) < PANEL_HEIGHT && 32'(it_r.read_col) < PANEL_WIDTH)
                   ? prd : 8'd0;
        st_nxt = S_DONE;
      end
      S_DONE: begin
        out_v_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  logic out_v_r;
  out_item_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR; cc_r <= 8'd16; thr_r <= 7'd60; frows_r <= 5'd8; base_r <= 8'd0;
      live_r <= '0; row_r <= '0; col_r <= '0; out_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt; live_r <= live_nxt; row_r <= row_nxt; col_r <= col_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_COLOR_COUNT: cc_r <= cfg_data;
          CFG_SPAWN_THR:   thr_r <= cfg_data[6:0];
          CFG_FLARE_ROWS:  frows_r <= cfg_data[4:0];
          CFG_COLOR_BASE:  base_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    it_r <= it_nxt; k_r <= k_nxt; m_r <= m_nxt; spawn_r <= spawn_nxt;
    fx_r <= fx_nxt; fy_r <= fy_nxt; fz_r <= fz_nxt;
    r0_r <= r0_nxt; r1_r <= r1_nxt; c0_r <= c0_nxt; c1_r <= c1_nxt;
    sq_r <= sq_nxt;
    if (st_r == S_IDLE) rint_r <= 8'd0; else rint_r <= rint_nxt;
    if (st_r == S_DONE) begin
      out_r.intensity   <= rint_r;
      out_r.color_index <= (it_r.operation == OP_READ) ? rint_r + base_r : 8'd0;
      out_r.flare_count <= live_r;
    end
  end

  assign busy = (st_r != S_IDLE);
  assign out_valid = out_v_r;
  assign out_item = out_r;

  a_live_max: assert property (@(posedge clk) disable iff (!rst_n) live_r <= NFL)
    else $error("too many flares");
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DONE |=> out_valid) else $error("missing result");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> st_r == S_IDLE) else $error("result outside idle");
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !out_valid || $past(st_r) == S_DONE) else $error("stray result");
endmodule
`default_nettype wire
